// ===== src/bcve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcve_pkg
// Shared types and constants of the bounded byte vector engine.
// ----------------------------------------------------------------------------
package bcve_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 8;

  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h3F;

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_PUSH   = 2'd1;
  localparam logic [1:0] ACT_POP    = 2'd2;
  localparam logic [1:0] ACT_SEARCH = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BYTE_W-1:0]  old_value;
    logic [INDEX_W-1:0] found_index;
    logic [LEN_W-1:0]   current_length;
  } out_word_t;

  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
  } store_req_t;

endpackage

// ===== src/bcve_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcve_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bcve_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/bcve_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcve_store
// Byte store: RAM plus per-entry valid bits; unwritten entries read as '?'.
// ----------------------------------------------------------------------------
module bcve_store
  import bcve_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  store_req_t        req_i,
  output logic [BYTE_W-1:0] rd_data_o
);

  logic [CAPACITY-1:0] valid_q;
  logic                rd_valid_q;
  logic [BYTE_W-1:0]   ram_data;

  bcve_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (req_i.wr_en),
    .wr_addr_i(req_i.wr_addr),
    .wr_data_i(req_i.wr_data),
    .rd_en_i  (req_i.rd_en),
    .rd_addr_i(req_i.rd_addr),
    .rd_data_o(ram_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? ram_data : FILL_BYTE;

endmodule

// ===== src/bounded_char_vector_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_char_vector_engine_top
// Bounded byte vector with set, push, pop and linear search.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of in_word_t words (action, index, value).
//   out_* : valid/ready channel of out_word_t words, one per input word.
//   cfg_* : valid/ready write of initial_length; reloads the length
//           (saturated at the capacity) and makes every entry read '?'.
// Steps from accept to out_valid_o:
//   push, pop, set out of range, search on empty vector: straight to the
//   result register; set in range: RAM read, then write back; search:
//   one RAM read per cycle over the entries scanned, up to length entries.
// Every result then moves from the result register to the output register.
// One word is in work at a time; the next is taken once the result has
// moved to the output register, so a stalled receiver holds one result
// while the next word is processed, then blocks further words.
// Reset: length 0, all entries read '?', no clearing pass needed.
// ----------------------------------------------------------------------------
module bounded_char_vector_engine_top
  import bcve_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_word_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SET  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

  logic [1:0]        state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  ptr_q, ptr_d;
  logic [LEN_W-1:0]  ptr_nxt;
  in_word_t          item_q, item_d;
  out_word_t         res_q, res_d;
  out_word_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;
  store_req_t        req;
  logic [BYTE_W-1:0] rd_data;

  bcve_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rd_data_o(rd_data)
  );

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign ptr_nxt     = ptr_q + LEN_W'(1);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    req         = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          len_d     = (cfg_data_i > CAP_LEN) ? CAP_LEN : cfg_data_i;
          req.clear = 1'b1;
        end else if (in_valid_i) begin
          item_d               = in_data_i;
          res_d                = '0;
          res_d.current_length = len_q;
          state_d              = S_DONE;
          case (in_data_i.action)
            ACT_SET: begin
              if (LEN_W'(in_data_i.index) < len_q) begin
                req.rd_en   = 1'b1;
                req.rd_addr = ADDR_W'(in_data_i.index);
                state_d     = S_SET;
              end else begin
                res_d.status = ST_RANGE;
              end
            end
            ACT_PUSH: begin
              if (len_q < CAP_LEN) begin
                req.wr_en            = 1'b1;
                req.wr_addr          = len_q[ADDR_W-1:0];
                req.wr_data          = in_data_i.value;
                len_d                = len_q + LEN_W'(1);
                res_d.current_length = len_q + LEN_W'(1);
              end else begin
                res_d.status = ST_FULL;
              end
            end
            ACT_POP: begin
              if (len_q != '0) begin
                len_d                = len_q - LEN_W'(1);
                res_d.current_length = len_q - LEN_W'(1);
              end
            end
            default: begin
              if (len_q == '0) begin
                res_d.status = ST_MISS;
              end else begin
                req.rd_en   = 1'b1;
                req.rd_addr = '0;
                ptr_d       = '0;
                state_d     = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SET: begin
        res_d.old_value = rd_data;
        req.wr_en       = 1'b1;
        req.wr_addr     = ADDR_W'(item_q.index);
        req.wr_data     = item_q.value;
        state_d         = S_DONE;
      end
      S_SCAN: begin
        if (rd_data == item_q.value) begin
          res_d.found_index = INDEX_W'(ptr_q);
          state_d           = S_DONE;
        end else if (ptr_nxt >= len_q) begin
          res_d.status = ST_MISS;
          state_d      = S_DONE;
        end else begin
          ptr_d       = ptr_nxt;
          req.rd_en   = 1'b1;
          req.rd_addr = ptr_nxt[ADDR_W-1:0];
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/vector_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_checker
// Watches the input, output and length-write channels of the byte vector
// engine. It keeps a shadow copy of the vector, works out the result word of
// every accepted action, and compares each accepted result word with the
// oldest one it worked out.
// ----------------------------------------------------------------------------
module vector_checker
  import bcve_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_word_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_word_t        out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  output int               mismatch_count_o,
  output int               pending_o
);

  localparam int REPORT_CAP = 100;

  logic [BYTE_W-1:0] shadow_bytes [CAPACITY];
  int unsigned       shadow_len;
  out_word_t         predicted_q [$];
  int                mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic void reload_vector(input logic [LEN_W-1:0] len);
    shadow_len = (len > CAPACITY) ? CAPACITY : len;
    foreach (shadow_bytes[i]) shadow_bytes[i] = FILL_BYTE;
  endfunction

  function automatic out_word_t apply_action(input in_word_t w);
    out_word_t r;
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_SET: begin
        if (w.index < shadow_len) begin
          r.old_value = shadow_bytes[w.index];
          shadow_bytes[w.index] = w.value;
        end else begin
          r.status = ST_RANGE;
        end
      end
      ACT_PUSH: begin
        if (shadow_len < CAPACITY) begin
          shadow_bytes[shadow_len] = w.value;
          shadow_len++;
        end else begin
          r.status = ST_FULL;
        end
      end
      ACT_POP: begin
        if (shadow_len > 0) shadow_len--;
      end
      default: begin
        r.status = ST_MISS;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_bytes[i] == w.value) begin
            r.status = ST_OK;
            r.found_index = INDEX_W'(i);
            break;
          end
        end
      end
    endcase
    r.current_length = LEN_W'(shadow_len);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    int        moved;
    if (!rst_ni) begin
      reload_vector('0);
      predicted_q.delete();
      pending_o <= 0;
    end else begin
      moved = 0;
      // a result word always arrives after its action was taken
      if (out_valid_i && out_ready_i) begin
        if (predicted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $error("result word with nothing pending: %p", out_data_i);
        end else begin
          want = predicted_q.pop_front();
          moved--;
          check_field("status", want.status, out_data_i.status);
          check_field("old_value", want.old_value, out_data_i.old_value);
          check_field("found_index", want.found_index, out_data_i.found_index);
          check_field("current_length", want.current_length, out_data_i.current_length);
        end
      end
      if (cfg_valid_i && cfg_ready_i) reload_vector(cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        predicted_q.push_back(apply_action(in_data_i));
        moved++;
      end
      pending_o <= pending_o + moved;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the byte vector engine with a short directed sequence (empty and
// full vector, out-of-range set, search hits, misses and stale entries) and
// then random set/push/pop/search words over several length settings, with
// random gaps on both sides, one long output stall and one drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import bcve_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_SLACK = CAPACITY + 16;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  in_word_t         in_data_i   = '0;
  logic             out_ready_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic [LEN_W-1:0] cfg_data_i  = '0;
  logic             in_ready_o;
  logic             out_valid_o;
  out_word_t        out_data_o;
  logic             cfg_ready_o;

  int          mismatch_count;
  int          pending_words;
  int unsigned cycle_count = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned fill_est = 0;
  int unsigned words_sent = 0;
  int unsigned lengths_loaded = 0;
  int unsigned stalls_done = 0;

  bounded_char_vector_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  vector_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_words)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        stalls_done++;
      end
      out_ready_i <= !(rx_gaps && $urandom_range(99) < 15);
    end
  end

  function automatic in_word_t make_word(input logic [1:0] act,
                                         input logic [INDEX_W-1:0] idx,
                                         input logic [BYTE_W-1:0] val);
    in_word_t w;
    w.action = act;
    w.index  = idx;
    w.value  = val;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)      w.action = ACT_PUSH;
    else if (pick < 55) w.action = ACT_POP;
    else if (pick < 78) w.action = ACT_SET;
    else                w.action = ACT_SEARCH;
    // a few recurring bytes so searches hit often
    if ($urandom_range(99) < 40) begin
      case ($urandom_range(3))
        0:       w.value = FILL_BYTE;
        1:       w.value = 8'h00;
        2:       w.value = 8'hFF;
        default: w.value = 8'hA5;
      endcase
    end else begin
      w.value = BYTE_W'($urandom_range(255));
    end
    pick = $urandom_range(99);
    if (fill_est > 0 && pick < 70)
      w.index = INDEX_W'($urandom_range(fill_est - 1));
    else if (fill_est < CAPACITY && pick < 80)
      w.index = INDEX_W'(fill_est);
    else
      w.index = INDEX_W'($urandom_range(255));
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (tx_gaps && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 15);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (w.action == ACT_PUSH && fill_est < CAPACITY) fill_est++;
    if (w.action == ACT_POP && fill_est > 0) fill_est--;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words > 0);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    fill_est = (len > CAPACITY) ? CAPACITY : len;
    lengths_loaded++;
  endtask

  task automatic run_random_phase(input logic [LEN_W-1:0] len, input int unsigned count,
                                  input bit hold_mid, input bit pause_mid);
    drain_results();
    write_length(len);
    for (int unsigned n = 0; n < count; n++) begin
      if (hold_mid && n == count / 4) hold_req <= 1'b1;
      if (pause_mid && n == count / 2) drain_results();
      send_word(random_word());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty vector after reset
    send_word(make_word(ACT_POP, 8'd0, 8'h00));
    send_word(make_word(ACT_SEARCH, 8'd0, FILL_BYTE));
    send_word(make_word(ACT_SET, 8'd0, 8'h11));
    send_word(make_word(ACT_PUSH, 8'd0, 8'h00));
    send_word(make_word(ACT_PUSH, 8'd0, 8'hFF));
    send_word(make_word(ACT_PUSH, 8'd0, FILL_BYTE));
    send_word(make_word(ACT_SEARCH, 8'd0, 8'hFF));
    send_word(make_word(ACT_SEARCH, 8'd0, FILL_BYTE));
    send_word(make_word(ACT_SET, 8'd1, 8'hAA));
    send_word(make_word(ACT_SET, 8'd3, 8'h22));
    send_word(make_word(ACT_SET, 8'd255, 8'h33));
    send_word(make_word(ACT_SEARCH, 8'd0, 8'h55));
    // popped byte must stay invisible, push must overwrite it
    send_word(make_word(ACT_POP, 8'd0, 8'h00));
    send_word(make_word(ACT_SEARCH, 8'd0, FILL_BYTE));
    send_word(make_word(ACT_PUSH, 8'd0, 8'h55));
    send_word(make_word(ACT_SEARCH, 8'd0, 8'h55));

    // full vector
    drain_results();
    write_length(LEN_W'(CAPACITY));
    send_word(make_word(ACT_PUSH, 8'd0, 8'h01));
    send_word(make_word(ACT_SET, 8'd255, 8'h80));
    send_word(make_word(ACT_SEARCH, 8'd0, 8'h80));
    send_word(make_word(ACT_SEARCH, 8'd0, FILL_BYTE));
    send_word(make_word(ACT_SEARCH, 8'd0, 8'h7E));
    send_word(make_word(ACT_POP, 8'd0, 8'h00));
    send_word(make_word(ACT_PUSH, 8'd0, 8'h7E));
    send_word(make_word(ACT_SET, 8'd0, 8'h00));

    run_random_phase(LEN_W'(511), 150, 1'b0, 1'b0);
    run_random_phase(LEN_W'(0), 400, 1'b0, 1'b0);
    run_random_phase(LEN_W'(1), 325, 1'b1, 1'b0);
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    run_random_phase(LEN_W'(255), 175, 1'b0, 1'b0);
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;
    run_random_phase(LEN_W'(CAPACITY), 200, 1'b0, 1'b0);
    run_random_phase(LEN_W'($urandom_range(40, 2)), 400, 1'b0, 1'b1);

    drain_results();
    repeat (DRAIN_SLACK) @(posedge clk_i);
    $display("Covered set/push/pop/search with out-of-range, full, empty-pop and miss cases;");
    $display("%0d words, %0d length loads (0..511), %0d long output stall(s), %0d cycles",
             words_sent, lengths_loaded, stalls_done, cycle_count);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bcve_pkg.sv
src/bcve_ram.sv
src/bcve_store.sv
src/bounded_char_vector_engine_top.sv
tb/vector_checker.sv
tb/testbench.sv
